// ===== rtl/c_comment_stripper_macros.svh =====
// Assertion macros shared by the comment stripper RTL.
`ifndef C_COMMENT_STRIPPER_MACROS_SVH
`define C_COMMENT_STRIPPER_MACROS_SVH

// Same-cycle implication, ignored while in reset
`define CCS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while in reset
`define CCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/ccs_pkg.sv =====
package ccs_pkg;

    // Character codes with a meaning to the stripper
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_SLASH     = 8'h2F;
    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_SPACE     = 8'h20;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // One queue entry: the results caused by one input request
    typedef struct packed {
        logic first_vld;
        t_out first;
        logic second_vld;
        t_out second;
    } t_q_entry;

endpackage

// ===== rtl/c_comment_stripper.sv =====
// C/C++ comment stripper.
// Input channel: i_valid / i_data (text_byte, end_of_text), stalled by o_stall.
// Output channel: o_valid / o_data (out_byte, out_last), stalled by i_stall.
// A request moves when valid is high and stall is low at a rising edge.
// Each byte is held back until the next one arrives, since opening a comment
// blanks the byte before it; the byte flagged end_of_text releases the held
// byte and itself, the second with out_last set, then state returns to reset.
// Throughput is one byte per cycle while o_stall is low; a final byte yields two outputs.
// A released byte reaches o_data through the queue, written at the edge that
// accepts the request releasing it, and then the output register in the back
// part; the queue holds four entries.
// o_stall rises only when the queue is full, so input keeps flowing while a
// result waits at a stalled output until the queue fills.
// Synchronous reset (i_rst_n low) clears the classifier state, empties the
// queue and drops any pending output.
module c_comment_stripper
    import ccs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_in  i_data,
    output logic o_stall,
    output logic o_valid,
    output t_out o_data,
    input  logic i_stall
);

    logic     q_full;
    logic     q_push;
    logic     q_pop;
    logic     q_valid;
    t_q_entry q_in;
    t_q_entry q_head;

    // Front: classify bytes, build results
    ccs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_data   (i_data),
        .o_stall  (o_stall),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_entry  (q_in)
    );

    // Decoupling queue
    ccs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Back: serialise results to the output register
    ccs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_head  (q_head),
        .o_pop     (q_pop),
        .o_valid   (o_valid),
        .o_data    (o_data),
        .i_stall   (i_stall)
    );

endmodule

// ===== rtl/ccs_front.sv =====
`include "c_comment_stripper_macros.svh"

module ccs_front
    import ccs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in      i_data,
    output logic     o_stall,
    input  logic     i_q_full,
    output logic     o_push,
    output t_q_entry o_entry
);

    logic [7:0] r_prev_char;
    logic       r_prev_present;
    logic       r_prev_blanked;
    logic       r_chr;
    logic       r_str;
    logic       r_line;
    logic       r_block;
    logic       r_bs_odd;

    logic [7:0] n_prev_char;
    logic       n_prev_present;
    logic       n_prev_blanked;
    logic       n_chr;
    logic       n_str;
    logic       n_line;
    logic       n_block;
    logic       n_bs_odd;

    logic       accept;
    logic       cmt_active;
    logic       prev_slash;
    logic       prev_bslash;
    logic       prev_star;
    logic       code;
    logic       blank_prev;
    logic       cur_blank;
    logic [7:0] c;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign c       = i_data.text_byte;

    // Classify the byte against the literal and comment state
    always_comb begin
        cmt_active  = r_line || r_block;
        prev_slash  = r_prev_present && (r_prev_char == CH_SLASH);
        prev_bslash = r_prev_present && (r_prev_char == CH_BACKSLASH);
        prev_star   = r_prev_present && (r_prev_char == CH_STAR);
        blank_prev  = 1'b0;
        cur_blank   = cmt_active;
        n_str       = r_str;
        n_chr       = r_chr;
        n_line      = r_line;
        n_block     = r_block;

        // string literal: closing quote needs an even backslash run
        if (c == CH_DQUOTE && !cmt_active && !r_chr) begin
            if (!r_str) begin
                n_str = 1'b1;
            end else if (!r_bs_odd) begin
                n_str = 1'b0;
            end
        end
        // char literal: closing quote ignored after any backslash
        if (c == CH_SQUOTE && !cmt_active && !n_str) begin
            if (!r_chr) begin
                n_chr = 1'b1;
            end else if (!prev_bslash) begin
                n_chr = 1'b0;
            end
        end

        code = !cmt_active && !n_chr && !n_str;
        case (c)
            CH_SLASH: begin
                if (code && prev_slash) begin
                    n_line     = 1'b1;
                    blank_prev = 1'b1;
                    cur_blank  = 1'b1;
                end else if (r_block && prev_star) begin
                    n_block   = 1'b0;
                    cur_blank = 1'b1;
                end
            end
            CH_STAR: begin
                if (code && prev_slash) begin
                    n_block    = 1'b1;
                    blank_prev = 1'b1;
                    cur_blank  = 1'b1;
                end
            end
            CH_NEWLINE: begin
                // a continued line comment swallows the newline
                if (r_line && !prev_bslash) begin
                    n_line    = 1'b0;
                    cur_blank = 1'b0;
                end
            end
            default: begin
            end
        endcase

        n_bs_odd = (c == CH_BACKSLASH) ? !r_bs_odd : 1'b0;

        n_prev_char    = c;
        n_prev_present = 1'b1;
        n_prev_blanked = cur_blank;

        // end of text drops everything back to the reset state
        if (i_data.end_of_text) begin
            n_prev_char    = 8'h00;
            n_prev_present = 1'b0;
            n_prev_blanked = 1'b0;
            n_str          = 1'b0;
            n_chr          = 1'b0;
            n_line         = 1'b0;
            n_block        = 1'b0;
            n_bs_odd       = 1'b0;
        end
    end

    // Results of this request: held byte, then current byte on end of text
    always_comb begin
        o_entry.first_vld       = r_prev_present;
        o_entry.first.out_byte  = (r_prev_blanked || blank_prev) ? CH_SPACE : r_prev_char;
        o_entry.first.out_last  = 1'b0;
        o_entry.second_vld      = i_data.end_of_text;
        o_entry.second.out_byte = cur_blank ? CH_SPACE : c;
        o_entry.second.out_last = 1'b1;
        o_push = accept && (r_prev_present || i_data.end_of_text);
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_char    <= 8'h00;
            r_prev_present <= 1'b0;
            r_prev_blanked <= 1'b0;
            r_chr          <= 1'b0;
            r_str          <= 1'b0;
            r_line         <= 1'b0;
            r_block        <= 1'b0;
            r_bs_odd       <= 1'b0;
        end else if (accept) begin
            r_prev_char    <= n_prev_char;
            r_prev_present <= n_prev_present;
            r_prev_blanked <= n_prev_blanked;
            r_chr          <= n_chr;
            r_str          <= n_str;
            r_line         <= n_line;
            r_block        <= n_block;
            r_bs_odd       <= n_bs_odd;
        end
    end

    `CCS_ASSERT_NOW(a_modes_exclusive, i_clk, i_rst_n, 1'b1, $onehot0({r_line, r_block, r_str, r_chr}), "literal and comment modes overlap")
    `CCS_ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, accept && i_data.end_of_text, !r_prev_present && !r_line && !r_block, "state not cleared after end of text")
    `CCS_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, o_push, !i_q_full, "push into full queue")

endmodule

// ===== rtl/ccs_queue.sv =====
`include "c_comment_stripper_macros.svh"

module ccs_queue
    import ccs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_q_entry i_entry,
    output logic     o_full,
    input  logic     i_pop,
    output logic     o_valid,
    output t_q_entry o_head
);

    t_q_entry                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]     r_wr_ptr;
    logic [QUEUE_AW-1:0]     r_rd_ptr;
    logic [QUEUE_CW-1:0]     r_count;

    assign o_full  = (r_count == QUEUE_CW'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `CCS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= QUEUE_CW'(QUEUE_DEPTH), "queue count beyond depth")
    `CCS_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, o_valid, "pop from empty queue")

endmodule

// ===== rtl/ccs_back.sv =====
`include "c_comment_stripper_macros.svh"

module ccs_back
    import ccs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_q_valid,
    input  t_q_entry i_q_head,
    output logic     o_pop,
    output logic     o_valid,
    output t_out     o_data,
    input  logic     i_stall
);

    logic r_first_vld;
    logic r_second_vld;
    t_out r_first;
    t_out r_second;

    logic take;
    logic last_taken;
    logic empty;

    assign o_valid    = r_first_vld || r_second_vld;
    assign o_data     = r_first_vld ? r_first : r_second;
    assign take       = o_valid && !i_stall;
    assign empty      = !r_first_vld && !r_second_vld;
    // the request being taken is the only one left in the register
    assign last_taken = take && (r_first_vld ^ r_second_vld);
    assign o_pop      = i_q_valid && (empty || last_taken);

    // Output valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_vld  <= 1'b0;
            r_second_vld <= 1'b0;
        end else if (o_pop) begin
            r_first_vld  <= i_q_head.first_vld;
            r_second_vld <= i_q_head.second_vld;
        end else if (take) begin
            if (r_first_vld) begin
                r_first_vld <= 1'b0;
            end else begin
                r_second_vld <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_first  <= i_q_head.first;
            r_second <= i_q_head.second;
        end
    end

    `CCS_ASSERT_NOW(a_first_not_last, i_clk, i_rst_n, r_first_vld, !r_first.out_last, "held byte flagged last")
    `CCS_ASSERT_NOW(a_second_is_last, i_clk, i_rst_n, r_second_vld, r_second.out_last, "final byte not flagged last")

endmodule
